// ===== rtl/sege_pkg.sv =====
// Shared types and constants for the signed Elias gamma encoder.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps
package sege_pkg;

   localparam int VALUE_BITS  = 31;
   // Width of the mapped code number: a negative value doubles its magnitude.
   localparam int CODE_BITS   = VALUE_BITS + 1;
   localparam int LEN_BITS    = $clog2(CODE_BITS + 1);
   localparam int BYTE_BITS   = 8;
   localparam int PEND_BITS   = BYTE_BITS - 1;
   // Longest run of bits held at once: pending bits plus the longest code.
   localparam int MAX_RUN     = PEND_BITS + 2 * CODE_BITS - 1;
   localparam int WIN_BITS    = ((MAX_RUN + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
   localparam int CNT_BITS    = $clog2(WIN_BITS + 1);
   localparam int REQ_DATA_BITS = ((VALUE_BITS + BYTE_BITS - 1) / BYTE_BITS) * BYTE_BITS;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic REQ_ENCODE = 1'b0;
   localparam logic REQ_FLUSH  = 1'b1;

   typedef struct packed {
      logic                 flush;
      logic [CODE_BITS-1:0] code;
      logic [LEN_BITS-1:0]  len;
   } entry_type;

endpackage

// ===== rtl/sege_front.sv =====
// Front end: accepts requests, maps the signed value to its code number and
// finds the code length. Depends on sege_pkg.
`timescale 1ns / 1ps
module sege_front import sege_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_type,
   input  logic [VALUE_BITS-1:0] in_value,
   output logic                  q_wr_valid,
   input  logic                  q_wr_ready,
   output entry_type             q_wr_entry
);

   logic                  valid_ff, valid_in;
   logic                  flush_ff;
   logic [CODE_BITS-1:0]  code_ff, code_in;
   logic [VALUE_BITS-1:0] neg_mag;
   logic [LEN_BITS-1:0]   len;
   logic                  accept;

   assign in_ready = !valid_ff || q_wr_ready;
   assign accept   = in_valid && in_ready;

   // Negative x maps to -2x, non-negative x to 2x+1.
   assign neg_mag = ~in_value + VALUE_BITS'(1);
   always_comb begin
      if (in_value[VALUE_BITS-1]) begin
         code_in = {neg_mag, 1'b0};
      end else begin
         code_in = {in_value, 1'b1};
      end
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_wr_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         flush_ff <= in_type;
         code_ff  <= code_in;
      end
   end

   // Position of the leading one gives the code length.
   always_comb begin
      len = '0;
      for (int i = 0; i < CODE_BITS; i++) begin
         if (code_ff[i]) begin
            len = LEN_BITS'(i + 1);
         end
      end
   end

   assign q_wr_valid       = valid_ff;
   assign q_wr_entry.flush = flush_ff;
   assign q_wr_entry.code  = code_ff;
   assign q_wr_entry.len   = len;

endmodule

// ===== rtl/sege_queue.sv =====
// Small FIFO that decouples the front end from the bit packer.
// Depends on sege_pkg for the entry type and depth.
`timescale 1ns / 1ps
module sege_queue import sege_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_valid,
   output logic      wr_ready,
   input  entry_type wr_entry,
   output logic      rd_valid,
   input  logic      rd_pop,
   output entry_type rd_entry
);

   entry_type            store_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wptr_ff, wptr_in;
   logic [QPTR_BITS-1:0] rptr_ff, rptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 push;
   logic                 pop;

   assign wr_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_pop && rd_valid;
   assign rd_entry = store_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + QPTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wptr_ff] <= wr_entry;
      end
   end

endmodule

// ===== rtl/sege_back.sv =====
// Back end: merges each code into the bit window and emits full bytes,
// most significant bit first, through an output register. Depends on sege_pkg.
`timescale 1ns / 1ps
module sege_back import sege_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  entry_type            q_entry,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [BYTE_BITS-1:0] out_byte,
   output logic                 out_last
);

   // Window holds the pending bit run left-aligned; the bits below it are zero.
   logic [WIN_BITS-1:0]  window_ff, window_in;
   logic [CNT_BITS-1:0]  bits_ff, bits_in;
   logic                 valid_ff, valid_in;
   logic [BYTE_BITS-1:0] byte_ff;
   logic                 last_ff;
   logic                 out_free;
   logic                 emit;
   logic                 emit_last;
   logic [CNT_BITS-1:0]  total;
   logic [CNT_BITS-1:0]  shift;
   logic [CNT_BITS-1:0]  code_len;

   assign out_free = !valid_ff || out_ready;
   assign code_len = CNT_BITS'({q_entry.len, 1'b0}) - CNT_BITS'(1);
   assign total    = bits_ff + code_len;
   assign shift    = CNT_BITS'(WIN_BITS) - total;

   always_comb begin
      window_in = window_ff;
      bits_in   = bits_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      emit_last = 1'b0;
      if (bits_ff >= CNT_BITS'(BYTE_BITS)) begin
         if (out_free) begin
            emit      = 1'b1;
            emit_last = (bits_ff < CNT_BITS'(2 * BYTE_BITS));
            window_in = window_ff << BYTE_BITS;
            bits_in   = bits_ff - CNT_BITS'(BYTE_BITS);
         end
      end else if (q_valid) begin
         if (q_entry.flush == REQ_FLUSH) begin
            if (bits_ff == '0) begin
               q_pop = 1'b1;
            end else if (out_free) begin
               // The zero padding is already in place below the pending bits.
               q_pop     = 1'b1;
               emit      = 1'b1;
               emit_last = 1'b1;
               window_in = '0;
               bits_in   = '0;
            end
         end else begin
            // Leading zeros come for free: the code sits right-aligned in a
            // field of 2L-1 bits just after the pending bits.
            q_pop     = 1'b1;
            window_in = window_ff | (WIN_BITS'(q_entry.code) << shift);
            bits_in   = total;
         end
      end
   end

   always_comb begin
      if (emit) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         bits_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         window_ff <= window_in;
         bits_ff   <= bits_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= window_ff[WIN_BITS-1 -: BYTE_BITS];
         last_ff <= emit_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

// ===== rtl/signed_elias_gamma_encoder_core.sv =====
// Signed Elias gamma encoder with MSB-first byte packing.
// A request passes the front-end register, the queue, the packer window and the
// output register before its first byte is valid on the result port.
// One request transfer per cycle while the 2-entry queue has room; the packer
// merges a code, then emits its full bytes before it takes the next one.
// Reset (synchronous, active high) clears pending bits, the queue and the output.
// Depends on sege_pkg, sege_front, sege_queue and sege_back.
`timescale 1ns / 1ps
module signed_elias_gamma_encoder_core import sege_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // [30:0] value, upper bits zero
   input  logic                     req_tuser,   // [0] req_type: 0 encode, 1 flush
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [BYTE_BITS-1:0]     rsp_tdata,   // [7:0] out_byte
   output logic                     rsp_tlast
);

   logic      q_wr_valid;
   logic      q_wr_ready;
   entry_type q_wr_entry;
   logic      q_rd_valid;
   logic      q_rd_pop;
   entry_type q_rd_entry;

   sege_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_type    (req_tuser),
      .in_value   (req_tdata[VALUE_BITS-1:0]),
      .q_wr_valid (q_wr_valid),
      .q_wr_ready (q_wr_ready),
      .q_wr_entry (q_wr_entry)
   );

   sege_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_wr_valid),
      .wr_ready (q_wr_ready),
      .wr_entry (q_wr_entry),
      .rd_valid (q_rd_valid),
      .rd_pop   (q_rd_pop),
      .rd_entry (q_rd_entry)
   );

   sege_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_rd_valid),
      .q_pop     (q_rd_pop),
      .q_entry   (q_rd_entry),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== bench/signed_elias_gamma_encoder_core_tb.sv =====
// Self-checking testbench for signed_elias_gamma_encoder_core: directed table plus random items.
// Expected bytes: a bit-level packer here or typed table bytes; depends on sege_pkg and the RTL.
`timescale 1ns / 1ps
module signed_elias_gamma_encoder_core_tb;
   import sege_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 450;
   localparam int IDLE_PCT     = 8;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } code_byte_type;

   // n_typed < 0 means the packer supplies the expected bytes for the row.
   typedef struct {
      logic                  kind;
      logic [VALUE_BITS-1:0] value;
      int                    n_typed;
      logic [63:0]           typed;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;   // [30:0] value, upper bits zero
   logic                     req_tuser = 1'b0; // [0] req_type: 0 encode, 1 flush
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [BYTE_BITS-1:0]     rsp_tdata;        // [7:0] out_byte
   logic                     rsp_tlast;

   code_byte_type expected_bytes[$];
   code_byte_type step_bytes[$];
   stim_row_type  stim_rows[$];

   // Packer state: bits collected so far, right aligned, and how many.
   logic [7:0] pend_bits = '0;
   logic [2:0] pend_cnt = '0;

   logic calm = 1'b0;
   int   error_count = 0;
   int   bytes_checked = 0;
   int   items_sent = 0;
   int   flushes_sent = 0;
   int   cycles = 0;

   signed_elias_gamma_encoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [8:0] want,
                                  input logic [8:0] got);
      $display("MISMATCH at cycle %0d: %s expected %h got %h", cycles, what, want, got);
      error_count++;
   endtask

   // Shifts one code bit into the accumulator; a full byte goes to step_bytes.
   task automatic pack_bit(input logic b);
      code_byte_type cb;
      if (pend_cnt == 3'd7) begin
         cb.data = {pend_bits[6:0], b};
         cb.last = 1'b0;
         step_bytes.push_back(cb);
         pend_bits = '0;
         pend_cnt = '0;
      end else begin
         pend_bits = {pend_bits[6:0], b};
         pend_cnt = pend_cnt + 3'd1;
      end
   endtask

   // Computes the bytes one request releases and advances the packer state.
   task automatic predict_gamma_bytes(input logic kind, input logic [VALUE_BITS-1:0] val);
      code_byte_type cb;
      logic [63:0]   code_num;
      logic [7:0]    shifted;
      int            len;
      int            i;
      step_bytes.delete();
      if (kind == REQ_FLUSH) begin
         if (pend_cnt != 3'd0) begin
            shifted = pend_bits << (4'd8 - {1'b0, pend_cnt});
            cb.data = shifted;
            cb.last = 1'b1;
            step_bytes.push_back(cb);
            pend_bits = '0;
            pend_cnt = '0;
         end
      end else begin
         // Negative values map to even code numbers, the rest to odd ones.
         if (val[VALUE_BITS-1])
            code_num = ((64'd1 << VALUE_BITS) - {{(64-VALUE_BITS){1'b0}}, val}) * 64'd2;
         else
            code_num = {{(64-VALUE_BITS){1'b0}}, val} * 64'd2 + 64'd1;
         len = 0;
         for (i = 0; i < 64; i++)
            if (code_num[i]) len = i + 1;
         for (i = 1; i < len; i++)
            pack_bit(1'b0);
         for (i = len - 1; i >= 0; i--)
            pack_bit(code_num[i]);
         if (step_bytes.size() > 0)
            step_bytes[step_bytes.size()-1].last = 1'b1;
      end
   endtask

   task automatic add_row(input logic kind, input logic [VALUE_BITS-1:0] val,
                          input int n_typed, input logic [63:0] typed);
      stim_row_type row;
      row.kind = kind;
      row.value = val;
      row.n_typed = n_typed;
      row.typed = typed;
      stim_rows.push_back(row);
   endtask

   // Queues the expected bytes, then holds the item on the bus until its transfer.
   task automatic send_item(input logic kind, input logic [VALUE_BITS-1:0] val,
                            input int n_typed, input logic [63:0] typed);
      code_byte_type cb;
      int            i;
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      predict_gamma_bytes(kind, val);
      if (n_typed < 0) begin
         for (i = 0; i < step_bytes.size(); i++)
            expected_bytes.push_back(step_bytes[i]);
      end else begin
         for (i = 0; i < n_typed; i++) begin
            cb.data = typed[63-8*i -: 8];
            cb.last = (i == n_typed - 1);
            expected_bytes.push_back(cb);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {{(REQ_DATA_BITS-VALUE_BITS){1'b0}}, val};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (kind == REQ_FLUSH) flushes_sent++;
   endtask

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      code_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch("unexpected byte", 9'h0, {rsp_tlast, rsp_tdata});
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.data)
               report_mismatch("out_byte", {1'b0, want.data}, {1'b0, rsp_tdata});
            if (rsp_tlast !== want.last)
               report_mismatch("last", {8'h0, want.last}, {8'h0, rsp_tlast});
            bytes_checked++;
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout with %0d bytes still expected", expected_bytes.size());
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      logic                  kind;
      logic [VALUE_BITS-1:0] val;
      logic [31:0]           raw;
      int                    pick;
      int                    n;

      // Flush on an empty accumulator and a lone one-bit code.
      add_row(REQ_FLUSH,  31'h0000_0000, 0, 64'h0);
      add_row(REQ_ENCODE, 31'h0000_0000, 0, 64'h0);
      add_row(REQ_FLUSH,  31'h0000_0000, 1, 64'h8000_0000_0000_0000);
      // Most negative value gives the longest code; seven zero bits stay pending.
      add_row(REQ_ENCODE, 31'h4000_0000, 7, 64'h0000_0001_0000_0000);
      add_row(REQ_FLUSH,  31'h0000_0000, 1, 64'h0);
      // Largest positive value leaves five ones pending.
      add_row(REQ_ENCODE, 31'h3FFF_FFFF, 7, 64'h0000_0003_FFFF_FF00);
      add_row(REQ_FLUSH,  31'h0000_0000, 1, 64'hF800_0000_0000_0000);
      add_row(REQ_ENCODE, 31'h7FFF_FFFF, -1, 64'h0);
      add_row(REQ_ENCODE, 31'h0000_0001, -1, 64'h0);
      add_row(REQ_ENCODE, 31'h7FFF_FFFE, -1, 64'h0);
      // The value field must be ignored on a flush.
      add_row(REQ_FLUSH,  31'h7FFF_FFFF, -1, 64'h0);
      // Seven pending bits ahead of the longest code release eight bytes at once.
      add_row(REQ_ENCODE, 31'h0000_0005, -1, 64'h0);
      add_row(REQ_ENCODE, 31'h4000_0000, -1, 64'h0);
      add_row(REQ_ENCODE, 31'h3FFF_FFFF, -1, 64'h0);
      add_row(REQ_FLUSH,  31'h2AAA_AAAA, -1, 64'h0);
      add_row(REQ_FLUSH,  31'h5555_5555, 0, 64'h0);
      add_row(REQ_ENCODE, 31'h2AAA_AAAA, -1, 64'h0);
      add_row(REQ_ENCODE, 31'h5555_5555, -1, 64'h0);
      add_row(REQ_FLUSH,  31'h0000_0000, -1, 64'h0);
      for (n = 0; n < 6; n++)
         add_row(REQ_ENCODE, 31'h0000_0000, -1, 64'h0);
      add_row(REQ_FLUSH,  31'h0000_0000, -1, 64'h0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[r])
         send_item(stim_rows[r].kind, stim_rows[r].value, stim_rows[r].n_typed,
                   stim_rows[r].typed);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         calm = (n >= 100 && n < 180);
         if (n == 250) begin
            // Let the encoder deliver every expected byte before going on.
            req_tvalid <= 1'b0;
            do @(posedge clock); while (expected_bytes.size() != 0);
         end
         pick = $urandom_range(99);
         raw = $urandom >> $urandom_range(1, 31);
         kind = (pick < 15) ? REQ_FLUSH : REQ_ENCODE;
         if (pick >= 15 && pick < 19)
            val = {1'b1, {(VALUE_BITS-1){1'b0}}};
         else if (pick >= 19 && pick < 22)
            val = {1'b0, {(VALUE_BITS-1){1'b1}}};
         else if ($urandom_range(1) == 1)
            val = ~raw[VALUE_BITS-1:0] + 1'b1;
         else
            val = raw[VALUE_BITS-1:0];
         send_item(kind, val, -1, 64'h0);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d requests (%0d flushes), checked %0d code bytes.",
               items_sent, flushes_sent, bytes_checked);
      $display("Covered empty flushes, longest codes, value extremes and stalls on both sides.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("%0d mismatches", error_count);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== signed_elias_gamma_encoder_core.f =====
rtl/sege_pkg.sv
rtl/sege_front.sv
rtl/sege_queue.sv
rtl/sege_back.sv
rtl/signed_elias_gamma_encoder_core.sv
bench/signed_elias_gamma_encoder_core_tb.sv
